@@ hw/rtl/directional_difference_energy_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the directional difference energy block
// Each macro checks an implication on the rising clock edge and is switched
// off while the asynchronous active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef DIRECTIONAL_DIFFERENCE_ENERGY_TOP_ASSERT_SVH
`define DIRECTIONAL_DIFFERENCE_ENERGY_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dde_pkg.sv @@
// ----------------------------------------------------------------------------
// dde_pkg
// Widths, register indices, status codes and helpers shared by the
// directional difference energy block and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package dde_pkg;

  // Payload widths
  localparam int PIXEL_W  = 8;
  localparam int ENERGY_W = 24;
  localparam int COUNT_W  = 25;
  localparam int STATUS_W = 2;

  // Configuration register widths
  localparam int STEP_W = 12;
  localparam int DIM_W  = 13;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd3;

  // Register values after reset
  localparam logic              RST_DIRECTION = 1'b0;
  localparam logic [STEP_W-1:0] RST_STEP      = 12'd1;
  localparam logic [DIM_W-1:0]  RST_WIDTH     = 13'd640;
  localparam logic [DIM_W-1:0]  RST_HEIGHT    = 13'd480;

  // Smallest frame dimension accepted
  localparam logic [DIM_W-1:0] MIN_DIM = 13'd4;

  // Arithmetic widths
  localparam int DIST_W    = STEP_W + DIM_W;
  localparam int SQ_W      = 2 * PIXEL_W;
  localparam int SUM_W     = 40;
  localparam int FRAC_W    = 8;
  localparam int SPLIT_W   = ENERGY_W - FRAC_W;
  localparam int DIV_CNT_W = $clog2(ENERGY_W);

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_PAIRS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_FAR  = 2'd2;

  // Clamps a frame dimension into [MIN_DIM, hi].
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned      hi);
    logic [DIM_W-1:0] r;
    if (v < MIN_DIM) begin
      r = MIN_DIM;
    end else if (32'(v) > hi) begin
      r = hi[DIM_W-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/dde_channels_if.sv @@
// ----------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for the incoming pixels and the per-frame results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dde_pixel_if import dde_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface dde_result_if import dde_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ENERGY_W-1:0] energy;
  logic [COUNT_W-1:0]  pair_count;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output energy, output pair_count, output status,
                  input ready);
  modport sink   (input valid, input energy, input pair_count, input status,
                  output ready);
endinterface

`default_nettype wire

@@ hw/rtl/directional_difference_energy_top.sv @@
// ----------------------------------------------------------------------------
// directional_difference_energy_top
// Mean squared difference between each gray pixel and its partner a set
// number of columns or rows back, reported once per frame.
// ----------------------------------------------------------------------------
// Usage. Gray pixels of a frame enter in raster order on pixel_i, one item
// per accepted valid/ready handshake. Each item whose partner lies step
// columns back (direction 0) or step rows back (direction 1) is differenced
// with it; the partner is read from a ring memory of recent pixels that is
// written with every item. After the last item of a frame one result item
// leaves on result_o with the truncated mean in unsigned Q16.8, the number
// of pairs and a status word.
// Throughput is one pixel per cycle while the input is open: the history
// memory is read and written once per item and the square-and-add stage
// works on the item in the next cycle. The last pixel of a frame closes
// the input until its result sits in the output register, after the 24-step
// shift-subtract divider when status is ok and the mean does not saturate,
// and longer while result_o.ready is low and an earlier result still waits.
// Configuration is written on the cfg port while no item is in flight.
// Reset clears the counters, the accumulators and the control registers; the history
// memory is not cleared and needs no clearing pass, since a partner is only
// read once it has been written in the current frame.
// ----------------------------------------------------------------------------
`default_nettype none

`include "directional_difference_energy_top_assert.svh"

module directional_difference_energy_top
  import dde_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8192,
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  dde_pixel_if.sink             pixel_i,
  dde_result_if.source          result_o
);

  localparam int AW    = $clog2(HISTORY_DEPTH);
  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_SEND
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers. The partner distance and the "too far" flag are
  // derived from the incoming write, so they are ready for the next item.
  // --------------------------------------------------------------------------
  logic              dir_q, dir_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DIM_W-1:0]  width_q, width_d;
  logic [DIM_W-1:0]  height_q, height_d;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic              far_q, far_d;
  logic [DIM_W-1:0]  width_clamp_c;

  always_comb begin
    dir_d    = dir_q;
    step_d   = step_q;
    width_d  = width_q;
    height_d = height_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DIRECTION:    dir_d    = cfg_data_i[0];
        CFG_STEP:         step_d   = cfg_data_i[STEP_W-1:0];
        CFG_FRAME_WIDTH:  width_d  = cfg_data_i[DIM_W-1:0];
        CFG_FRAME_HEIGHT: height_d = cfg_data_i[DIM_W-1:0];
        default: ;
      endcase
    end
    width_clamp_c = clamp_dim(width_d, MAX_WIDTH);
    if (dir_d) begin
      dist_d = {{DIM_W{1'b0}}, step_d} * {{STEP_W{1'b0}}, width_clamp_c};
    end else begin
      dist_d = {{DIM_W{1'b0}}, step_d};
    end
    far_d = dist_d > DIST_W'(HISTORY_DEPTH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q    <= RST_DIRECTION;
      step_q   <= RST_STEP;
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      dist_q   <= DIST_W'(RST_STEP);
      far_q    <= 1'b0;
    end else if (cfg_we_i) begin
      dir_q    <= dir_d;
      step_q   <= step_d;
      width_q  <= width_d;
      height_q <= height_d;
      dist_q   <= dist_d;
      far_q    <= far_d;
    end
  end

  // --------------------------------------------------------------------------
  // Front stage: position tracking, partner address and history access.
  // --------------------------------------------------------------------------
  state_e             state_q;
  logic               s1_valid_q, s1_pair_q, s1_zero_q, s1_last_q, s1_far_q;
  logic [PIXEL_W-1:0] s1_px_q;
  logic [PIXEL_W-1:0] rd_data_q;
  logic [AW-1:0]      wp_q;
  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;

  logic               in_ready;
  logic               pix_acc;
  logic [DIM_W-1:0]   w_c, h_c;
  logic               row_end_c, frame_end_c, has_partner_c;
  logic [DIST_W-1:0]  wp_ext_c;
  logic [AW-1:0]      rd_addr_c;

  // The input closes from the last item of a frame until its result has
  // been handed to the output register.
  assign in_ready      = (state_q == ST_IDLE) && !(s1_valid_q && s1_last_q);
  assign pixel_i.ready = in_ready;
  assign pix_acc       = pixel_i.valid && in_ready;

  always_comb begin
    w_c         = clamp_dim(width_q, MAX_WIDTH);
    h_c         = clamp_dim(height_q, MAX_HEIGHT);
    row_end_c   = (32'(col_q) + 32'd1) >= 32'(w_c);
    frame_end_c = row_end_c && ((32'(row_q) + 32'd1) >= 32'(h_c));
    if (dir_q) begin
      has_partner_c = 32'(row_q) >= 32'(step_q);
    end else begin
      has_partner_c = 32'(col_q) >= 32'(step_q);
    end
    // The ring index wraps at the history depth, which need not be a power
    // of two.
    wp_ext_c = DIST_W'(wp_q);
    if (wp_ext_c >= dist_q) begin
      rd_addr_c = AW'(wp_ext_c - dist_q);
    end else begin
      rd_addr_c = AW'(wp_ext_c + DIST_W'(HISTORY_DEPTH) - dist_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q       <= '0;
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= pix_acc;
      if (pix_acc) begin
        s1_last_q <= frame_end_c;
        if (wp_q == AW'(HISTORY_DEPTH - 1)) begin
          wp_q <= '0;
        end else begin
          wp_q <= wp_q + 1'b1;
        end
        if (row_end_c) begin
          col_q <= '0;
          if (frame_end_c) begin
            row_q <= '0;
          end else begin
            row_q <= row_q + 1'b1;
          end
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_px_q   <= pixel_i.pixel;
      s1_pair_q <= has_partner_c && !far_q;
      s1_zero_q <= (dist_q == '0);
      s1_far_q  <= far_q;
    end
  end

  // History ring: one write and one registered read per item. A read of the
  // entry being overwritten returns the older pixel, which is the partner
  // when the distance equals the depth.
  logic [PIXEL_W-1:0] hist_mem [HISTORY_DEPTH];

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      hist_mem[wp_q] <= pixel_i.pixel;
      rd_data_q      <= hist_mem[rd_addr_c];
    end
  end

  // --------------------------------------------------------------------------
  // Square-and-add stage with saturating accumulators.
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0]   acc_sum_q;
  logic [COUNT_W-1:0] acc_cnt_q;
  logic [PIXEL_W-1:0] partner_c, diff_c;
  logic [SQ_W-1:0]    sq_c;
  logic [SUM_W:0]     sum_wide_c;
  logic [SUM_W-1:0]   sum_new_c;
  logic [COUNT_W-1:0] cnt_new_c;

  always_comb begin
    partner_c = s1_zero_q ? s1_px_q : rd_data_q;
    if (s1_px_q >= partner_c) begin
      diff_c = s1_px_q - partner_c;
    end else begin
      diff_c = partner_c - s1_px_q;
    end
    sq_c       = {{PIXEL_W{1'b0}}, diff_c} * {{PIXEL_W{1'b0}}, diff_c};
    sum_wide_c = {1'b0, acc_sum_q} + (SUM_W + 1)'(sq_c);
    sum_new_c  = acc_sum_q;
    cnt_new_c  = acc_cnt_q;
    if (s1_pair_q) begin
      sum_new_c = sum_wide_c[SUM_W] ? '1 : sum_wide_c[SUM_W-1:0];
      if (acc_cnt_q != '1) begin
        cnt_new_c = acc_cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_sum_q <= '0;
      acc_cnt_q <= '0;
    end else if (s1_valid_q) begin
      if (s1_last_q) begin
        acc_sum_q <= '0;
        acc_cnt_q <= '0;
      end else begin
        acc_sum_q <= sum_new_c;
        acc_cnt_q <= cnt_new_c;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Frame-end sequencer: classify the frame, run the divider one quotient
  // bit per cycle and hand the result to the output register.
  // --------------------------------------------------------------------------
  logic [SUM_W-1:0]     dv_sum_q;
  logic [COUNT_W-1:0]   dv_cnt_q;
  logic                 dv_far_q;
  logic [COUNT_W-1:0]   rem_q;
  logic [ENERGY_W-1:0]  dvd_q;
  logic [DIV_CNT_W-1:0] div_ctr_q;
  logic [ENERGY_W-1:0]  res_energy_q;
  logic [COUNT_W-1:0]   res_cnt_q;
  logic [STATUS_W-1:0]  res_status_q;
  logic                 out_valid_q;
  logic [ENERGY_W-1:0]  out_energy_q;
  logic [COUNT_W-1:0]   out_cnt_q;
  logic [STATUS_W-1:0]  out_status_q;

  logic [COUNT_W:0]     r_sh_c, r_sub_c;
  logic                 r_ge_c;
  logic                 sat_c;

  always_comb begin
    r_sh_c  = {rem_q, dvd_q[ENERGY_W-1]};
    r_ge_c  = r_sh_c >= {1'b0, dv_cnt_q};
    r_sub_c = r_sh_c - {1'b0, dv_cnt_q};
    // The mean overflows the Q16.8 range when sum >= count * 2^16.
    sat_c   = {1'b0, dv_sum_q} >= {dv_cnt_q, {SPLIT_W{1'b0}}};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      dv_sum_q     <= '0;
      dv_cnt_q     <= '0;
      dv_far_q     <= 1'b0;
      rem_q        <= '0;
      dvd_q        <= '0;
      div_ctr_q    <= '0;
      res_energy_q <= '0;
      res_cnt_q    <= '0;
      res_status_q <= STATUS_OK;
      out_energy_q <= '0;
      out_cnt_q    <= '0;
      out_status_q <= STATUS_OK;
    end else begin
      // The output register loads from the send state once it is free, or
      // empties when its item is taken.
      if (state_q == ST_SEND && (!out_valid_q || result_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s1_valid_q && s1_last_q) begin
            dv_sum_q <= sum_new_c;
            dv_cnt_q <= cnt_new_c;
            dv_far_q <= s1_far_q;
            state_q  <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (dv_far_q) begin
            res_energy_q <= '0;
            res_cnt_q    <= '0;
            res_status_q <= STATUS_TOO_FAR;
            state_q      <= ST_SEND;
          end else if (dv_cnt_q == '0) begin
            res_energy_q <= '0;
            res_cnt_q    <= '0;
            res_status_q <= STATUS_NO_PAIRS;
            state_q      <= ST_SEND;
          end else if (sat_c) begin
            res_energy_q <= '1;
            res_cnt_q    <= dv_cnt_q;
            res_status_q <= STATUS_OK;
            state_q      <= ST_SEND;
          end else begin
            res_energy_q <= '0;
            res_cnt_q    <= dv_cnt_q;
            res_status_q <= STATUS_OK;
            rem_q        <= COUNT_W'(dv_sum_q[SUM_W-1:SPLIT_W]);
            dvd_q        <= {dv_sum_q[SPLIT_W-1:0], {FRAC_W{1'b0}}};
            div_ctr_q    <= DIV_CNT_W'(ENERGY_W - 1);
            state_q      <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q        <= r_ge_c ? r_sub_c[COUNT_W-1:0] : r_sh_c[COUNT_W-1:0];
          dvd_q        <= {dvd_q[ENERGY_W-2:0], 1'b0};
          res_energy_q <= {res_energy_q[ENERGY_W-2:0], r_ge_c};
          div_ctr_q    <= div_ctr_q - 1'b1;
          if (div_ctr_q == '0) begin
            state_q <= ST_SEND;
          end
        end
        ST_SEND: begin
          if (!out_valid_q || result_o.ready) begin
            out_energy_q <= res_energy_q;
            out_cnt_q    <= res_cnt_q;
            out_status_q <= res_status_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.energy     = out_energy_q;
  assign result_o.pair_count = out_cnt_q;
  assign result_o.status     = out_status_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `DDE_ASSERT_NEXT(a_frame_end_starts_prep, clk_i, rst_ni,
    s1_valid_q && s1_last_q, state_q == ST_PREP,
    "frame end did not start the result sequencer")
  `DDE_ASSERT_SAME(a_div_rem_below_divisor, clk_i, rst_ni,
    state_q == ST_DIV, rem_q < dv_cnt_q,
    "divider remainder reached the divisor")
  `DDE_ASSERT_NEXT(a_div_ends_in_send, clk_i, rst_ni,
    state_q == ST_DIV && div_ctr_q == '0, state_q == ST_SEND,
    "divider did not finish after the last quotient bit")
  `DDE_ASSERT_NEXT(a_pair_count_grows, clk_i, rst_ni,
    s1_valid_q && !s1_last_q, acc_cnt_q >= $past(acc_cnt_q),
    "pair count fell within a frame")

endmodule

`default_nettype wire
